>>> rtl/jdgc_pkg.sv
// Shared types, constants and the month offset table for the day number / date converter.
`default_nettype none

package jdgc_pkg;

    // Request direction codes
    localparam logic REQ_TO_DATE   = 1'b0;
    localparam logic REQ_TO_NUMBER = 1'b1;

    // Register stages in each conversion pipeline
    localparam int unsigned PIPE_STAGES = 7;

    // Calendar constants
    localparam int unsigned MARCH_EPOCH = 1721119;
    localparam int unsigned CYCLE_DAYS  = 146097;
    localparam int unsigned QUAD_DAYS   = 1461;
    localparam int unsigned FIVE_MONTHS = 153;
    localparam int unsigned CENTURY     = 100;
    localparam int unsigned SPAN_LOW    = 1721060;
    localparam int unsigned SPAN_HIGH   = 5373484;
    localparam int unsigned YEAR_MAX    = 9999;
    localparam int unsigned YEAR_BIAS   = 400;
    localparam int unsigned LAST_MONTH  = 12;
    localparam int unsigned EPOCH_SHIFT = MARCH_EPOCH - CYCLE_DAYS;

    // Reciprocals for division by constants
    // Floor reciprocals leave an estimate at most one low; a compare and subtract fixes it.
    localparam int unsigned CYC_SHIFT  = 32;
    localparam longint unsigned CYC_RECIP = (64'd1 << CYC_SHIFT) / CYCLE_DAYS;
    localparam int unsigned QUAD_SHIFT = 20;
    localparam int unsigned QUAD_RECIP = (1 << QUAD_SHIFT) / QUAD_DAYS;
    localparam int unsigned FM_SHIFT   = 16;
    localparam int unsigned FM_RECIP   = (1 << FM_SHIFT) / FIVE_MONTHS;
    // Ceiling reciprocals are exact over the value ranges used here.
    localparam int unsigned CENT_SHIFT = 20;
    localparam int unsigned CENT_RECIP = ((1 << CENT_SHIFT) + CENTURY - 1) / CENTURY;
    localparam int unsigned FIVE_SHIFT = 10;
    localparam int unsigned FIVE_RECIP = ((1 << FIVE_SHIFT) + 4) / 5;

    typedef struct packed {
        logic        req_type;
        logic [22:0] day_number;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
    } jdgc_req_t;

    typedef struct packed {
        logic [22:0] day_number_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        range_error;
    } jdgc_rsp_t;

    // Output of the day number to date pipeline
    typedef struct packed {
        logic        range_error;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } jdgc_date_t;

    // Output of the date to day number pipeline
    typedef struct packed {
        logic        range_error;
        logic [22:0] day_number;
    } jdgc_num_t;

    // Days from March 1 to the first of a March-based month 0..11
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] days;
        unique case (mon)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

>>> rtl/jdgc_date_pipe.sv
// Seven-stage pipeline that turns a Julian day number into year, month and day.
`default_nettype none

module jdgc_date_pipe (
    input  logic                 clk,
    input  jdgc_pkg::jdgc_req_t  req,
    output jdgc_pkg::jdgc_date_t date
);
    import jdgc_pkg::*;

    // Stage 1: rebase to March epoch, start the 400-year cycle quotient
    logic [21:0] shifted;
    logic        s1_err_reg, s1_err_next;
    logic [23:0] s1_q_reg, s1_q_next;
    logic [38:0] s1_prod_reg, s1_prod_next;

    // Stage 2: cycle remainder estimate
    logic [6:0]  s2_cent_est;
    logic        s2_err_reg;
    logic [6:0]  s2_cent_reg;
    logic [18:0] s2_rem_reg, s2_rem_next;

    // Stage 3: fix cycle quotient, start year-in-century quotient
    logic [17:0] s3_rem;
    logic        s3_err_reg;
    logic [6:0]  s3_cent_reg, s3_cent_next;
    logic [17:0] s3_u_reg, s3_u_next;
    logic [27:0] s3_prod_reg, s3_prod_next;

    // Stage 4: year remainder estimate
    logic [6:0]  s4_yic_est;
    logic        s4_err_reg;
    logic [6:0]  s4_cent_reg;
    logic [6:0]  s4_yic_reg;
    logic [11:0] s4_rem_reg, s4_rem_next;

    // Stage 5: fix year quotient, start month quotient
    logic [10:0] s5_rem;
    logic [10:0] s5_rem_up;
    logic [8:0]  s5_t;
    logic        s5_err_reg;
    logic [6:0]  s5_cent_reg;
    logic [6:0]  s5_yic_reg, s5_yic_next;
    logic [10:0] s5_u_reg, s5_u_next;
    logic [19:0] s5_prod_reg, s5_prod_next;

    // Stage 6: month remainder estimate, March-based year
    logic [3:0]  s6_mon_est;
    logic        s6_err_reg;
    logic [3:0]  s6_mon_reg;
    logic [8:0]  s6_rem_reg, s6_rem_next;
    logic [13:0] s6_year_reg, s6_year_next;

    // Stage 7: fix month, day of month, shift to January-based year
    logic [3:0]  s7_mon;
    logic [7:0]  s7_rem;
    logic [7:0]  s7_rem_up;
    logic [15:0] s7_day_prod;
    logic        s7_carry;
    jdgc_date_t  date_reg, date_next;

    always_comb
    begin
        s1_err_next  = (req.day_number < 23'(SPAN_LOW)) || (req.day_number > 23'(SPAN_HIGH));
        shifted      = 22'(req.day_number - 23'(EPOCH_SHIFT));
        s1_q_next    = {shifted, 2'b00} - 24'd1;
        s1_prod_next = 39'(s1_q_next) * 39'(CYC_RECIP);
    end

    always_comb
    begin
        s2_cent_est = s1_prod_reg[CYC_SHIFT +: 7];
        s2_rem_next = 19'(s1_q_reg - 24'(25'(s2_cent_est) * 25'(CYCLE_DAYS)));
    end

    always_comb
    begin
        if (s2_rem_reg >= 19'(CYCLE_DAYS))
        begin
            s3_rem       = 18'(s2_rem_reg - 19'(CYCLE_DAYS));
            s3_cent_next = s2_cent_reg + 7'd1;
        end
        else
        begin
            s3_rem       = s2_rem_reg[17:0];
            s3_cent_next = s2_cent_reg;
        end
        s3_u_next    = {s3_rem[17:2], 2'b11};
        s3_prod_next = 28'(s3_u_next) * 28'(QUAD_RECIP);
    end

    always_comb
    begin
        s4_yic_est  = s3_prod_reg[QUAD_SHIFT +: 7];
        s4_rem_next = 12'(s3_u_reg - 18'(18'(s4_yic_est) * 18'(QUAD_DAYS)));
    end

    always_comb
    begin
        if (s4_rem_reg >= 12'(QUAD_DAYS))
        begin
            s5_rem      = 11'(s4_rem_reg - 12'(QUAD_DAYS));
            s5_yic_next = s4_yic_reg + 7'd1;
        end
        else
        begin
            s5_rem      = s4_rem_reg[10:0];
            s5_yic_next = s4_yic_reg;
        end
        s5_rem_up    = s5_rem + 11'd4;
        s5_t         = s5_rem_up[10:2];
        s5_u_next    = {s5_t, 2'b00} + 11'(s5_t) - 11'd3;
        s5_prod_next = 20'(s5_u_next) * 20'(FM_RECIP);
    end

    always_comb
    begin
        s6_mon_est   = s5_prod_reg[FM_SHIFT +: 4];
        s6_rem_next  = 9'(s5_u_reg - 11'(11'(s6_mon_est) * 11'(FIVE_MONTHS)));
        s6_year_next = 14'(s5_cent_reg) * 14'(CENTURY) + 14'(s5_yic_reg);
    end

    always_comb
    begin
        if (s6_rem_reg >= 9'(FIVE_MONTHS))
        begin
            s7_rem = 8'(s6_rem_reg - 9'(FIVE_MONTHS));
            s7_mon = s6_mon_reg + 4'd1;
        end
        else
        begin
            s7_rem = s6_rem_reg[7:0];
            s7_mon = s6_mon_reg;
        end
        s7_rem_up   = s7_rem + 8'd5;
        s7_day_prod = 16'(s7_rem_up) * 16'(FIVE_RECIP);

        // January and February belong to the following calendar year
        if (s7_mon < 4'd10)
        begin
            date_next.month = s7_mon + 4'd3;
            s7_carry        = 1'b0;
        end
        else
        begin
            date_next.month = s7_mon - 4'd9;
            s7_carry        = 1'b1;
        end
        date_next.year        = s6_year_reg + 14'(s7_carry) - 14'(YEAR_BIAS);
        date_next.day         = s7_day_prod[FIVE_SHIFT +: 5];
        date_next.range_error = s6_err_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg  <= s1_err_next;
        s1_q_reg    <= s1_q_next;
        s1_prod_reg <= s1_prod_next;

        s2_err_reg  <= s1_err_reg;
        s2_cent_reg <= s2_cent_est;
        s2_rem_reg  <= s2_rem_next;

        s3_err_reg  <= s2_err_reg;
        s3_cent_reg <= s3_cent_next;
        s3_u_reg    <= s3_u_next;
        s3_prod_reg <= s3_prod_next;

        s4_err_reg  <= s3_err_reg;
        s4_cent_reg <= s3_cent_reg;
        s4_yic_reg  <= s4_yic_est;
        s4_rem_reg  <= s4_rem_next;

        s5_err_reg  <= s4_err_reg;
        s5_cent_reg <= s4_cent_reg;
        s5_yic_reg  <= s5_yic_next;
        s5_u_reg    <= s5_u_next;
        s5_prod_reg <= s5_prod_next;

        s6_err_reg  <= s5_err_reg;
        s6_mon_reg  <= s6_mon_est;
        s6_rem_reg  <= s6_rem_next;
        s6_year_reg <= s6_year_next;

        date_reg    <= date_next;
    end

    assign date = date_reg;

endmodule

`default_nettype wire

>>> rtl/jdgc_number_pipe.sv
// Seven-stage pipeline that turns year, month and day into a Julian day number.
`default_nettype none

module jdgc_number_pipe (
    input  logic                clk,
    input  jdgc_pkg::jdgc_req_t req,
    output jdgc_pkg::jdgc_num_t num
);
    import jdgc_pkg::*;

    localparam int unsigned PAD_STAGES = PIPE_STAGES - 4;

    // Stage 1: March-based year and month, day offset within the year
    logic [3:0]  s1_mon;
    logic        s1_err_reg, s1_err_next;
    logic [13:0] s1_year_reg, s1_year_next;
    logic [8:0]  s1_doff_reg, s1_doff_next;

    // Stage 2: century quotient product
    logic        s2_err_reg;
    logic [13:0] s2_year_reg;
    logic [8:0]  s2_doff_reg;
    logic [27:0] s2_prod_reg, s2_prod_next;

    // Stage 3: century and year within century
    logic [6:0]  s3_cent;
    logic        s3_err_reg;
    logic [6:0]  s3_cent_reg;
    logic [6:0]  s3_rem_reg, s3_rem_next;
    logic [8:0]  s3_doff_reg;

    // Stage 4: days in whole centuries and whole years
    logic [23:0] s4_cdays_full;
    logic [17:0] s4_rdays_full;
    logic        s4_err_reg;
    logic [21:0] s4_cdays_reg;
    logic [15:0] s4_rdays_reg;
    logic [8:0]  s4_doff_reg;

    // Stage 5 and padding
    jdgc_num_t   s5_next;
    jdgc_num_t   pad_reg [PAD_STAGES];

    always_comb
    begin
        s1_err_next = (req.year_in > 14'(YEAR_MAX)) || (req.month_in == 4'd0)
                   || (req.month_in > 4'(LAST_MONTH)) || (req.day_in == 5'd0);
        // Count from March so the leap day falls at the end of the year
        if (req.month_in > 4'd2)
        begin
            s1_mon       = req.month_in - 4'd3;
            s1_year_next = req.year_in + 14'(YEAR_BIAS);
        end
        else
        begin
            s1_mon       = req.month_in + 4'd9;
            s1_year_next = req.year_in + 14'(YEAR_BIAS) - 14'd1;
        end
        s1_doff_next = 9'(req.day_in) + month_offset(s1_mon);
    end

    assign s2_prod_next = 28'(s1_year_reg) * 28'(CENT_RECIP);

    always_comb
    begin
        s3_cent     = s2_prod_reg[CENT_SHIFT +: 7];
        s3_rem_next = 7'(s2_year_reg - 14'(14'(s3_cent) * 14'(CENTURY)));
    end

    always_comb
    begin
        s4_cdays_full = 24'(s3_cent_reg) * 24'(CYCLE_DAYS);
        s4_rdays_full = 18'(s3_rem_reg) * 18'(QUAD_DAYS);
    end

    always_comb
    begin
        s5_next.range_error = s4_err_reg;
        s5_next.day_number  = 23'(s4_cdays_reg) + 23'(s4_rdays_reg) + 23'(s4_doff_reg)
                            + 23'(EPOCH_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg  <= s1_err_next;
        s1_year_reg <= s1_year_next;
        s1_doff_reg <= s1_doff_next;

        s2_err_reg  <= s1_err_reg;
        s2_year_reg <= s1_year_reg;
        s2_doff_reg <= s1_doff_reg;
        s2_prod_reg <= s2_prod_next;

        s3_err_reg  <= s2_err_reg;
        s3_cent_reg <= s3_cent;
        s3_rem_reg  <= s3_rem_next;
        s3_doff_reg <= s2_doff_reg;

        s4_err_reg   <= s3_err_reg;
        s4_cdays_reg <= s4_cdays_full[23:2];
        s4_rdays_reg <= s4_rdays_full[17:2];
        s4_doff_reg  <= s3_doff_reg;

        // Hold the sum so both directions leave after the same number of stages
        pad_reg[0] <= s5_next;
        for (int i = 1; i < PAD_STAGES; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign num = pad_reg[PAD_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/julian_day_gregorian_date_convert_unit.sv
// Top level of the Julian day number / Gregorian date converter.
`default_nettype none

// Converts a Julian day number to a proleptic Gregorian date (req_type 0) or
// a date to a day number (req_type 1), over 0000-01-01 .. 9999-12-31.
// Request channel: a transfer happens at each rising edge with start high and
// busy low. busy is always low, so a request may be issued every cycle.
// Result channel: done is high for one cycle with the result on rsp; that
// cycle's closing edge is the transfer. The receiver has no way to stall.
// Each request runs through two parallel 7-stage pipelines (one per direction)
// and then the output register that drives done and rsp, so throughput is one
// item per cycle.
// Fields of the unused direction read 0. An input outside the span sets
// range_error with every other field 0. Day values past the month end are
// counted on into the next month.
// Reset clears the valid chain and done; items in flight are dropped.
module julian_day_gregorian_date_convert_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  jdgc_pkg::jdgc_req_t req,
    output logic                done,
    output jdgc_pkg::jdgc_rsp_t rsp
);
    import jdgc_pkg::*;

    localparam int unsigned RESULT_DELAY = PIPE_STAGES + 1;

    logic                   accept;
    logic [PIPE_STAGES-1:0] vld_reg, vld_next;
    logic [PIPE_STAGES-1:0] dir_reg, dir_next;
    logic                   done_reg, done_next;
    jdgc_rsp_t              rsp_reg, rsp_next;
    jdgc_date_t             date;
    jdgc_num_t              num;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    jdgc_date_pipe u_date_pipe (
        .clk  (clk),
        .req  (req),
        .date (date)
    );

    jdgc_number_pipe u_number_pipe (
        .clk (clk),
        .req (req),
        .num (num)
    );

    // Advance valid and direction alongside the data
    always_comb
    begin
        vld_next  = {vld_reg[PIPE_STAGES-2:0], accept};
        dir_next  = {dir_reg[PIPE_STAGES-2:0], req.req_type};
        done_next = vld_reg[PIPE_STAGES-1];
    end

    always_comb
    begin
        rsp_next = '0;
        if (dir_reg[PIPE_STAGES-1] == REQ_TO_DATE)
        begin
            if (date.range_error)
            begin
                rsp_next.range_error = 1'b1;
            end
            else
            begin
                rsp_next.year_out  = date.year;
                rsp_next.month_out = date.month;
                rsp_next.day_out   = date.day;
            end
        end
        else
        begin
            if (num.range_error)
            begin
                rsp_next.range_error = 1'b1;
            end
            else
            begin
                rsp_next.day_number_out = num.day_number;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg <= dir_next;
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##RESULT_DELAY done)
        else $error("request transfer without result transfer at fixed latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, RESULT_DELAY))
        else $error("result transfer without matching request transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.range_error |-> rsp.day_number_out == '0 && rsp.year_out == '0
                                    && rsp.month_out == '0 && rsp.day_out == '0)
        else $error("range error result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.range_error |-> (rsp.day_number_out != '0) != (rsp.month_out != '0))
        else $error("result mixes fields of both directions");
`endif

endmodule

`default_nettype wire
